@@ design/vlmr_pkg.sv @@
// ----------------------------------------------------------------------------
// vlmr_pkg: shared types and codes of the message ring FIFO
// Request and result payload structs, command, status and register codes,
// and the sequencer state type.
// ----------------------------------------------------------------------------
package vlmr_pkg;

   localparam int FILL_W = 11;

   // Commands carried by a request.
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_READ  = 1'b1;

   // Result status codes.
   localparam logic [2:0] STATUS_STORED    = 3'd0;
   localparam logic [2:0] STATUS_NO_SPACE  = 3'd1;
   localparam logic [2:0] STATUS_READ_BYTE = 3'd2;
   localparam logic [2:0] STATUS_TOO_SMALL = 3'd3;
   localparam logic [2:0] STATUS_EMPTY     = 3'd4;
   localparam logic [2:0] STATUS_BAD_LEN   = 3'd5;

   // Register index, taken from the word address.
   localparam logic CSR_BUFFER_SIZE = 1'b0;

   localparam logic [FILL_W-1:0] BUFFER_SIZE_RESET = 11'd1024;

   typedef struct packed {
      logic       command;
      logic [7:0] write_data;
      logic [7:0] request_size;
   } req_type;

   typedef struct packed {
      logic [7:0]        read_data;
      logic              last_byte;
      logic [2:0]        status;
      logic [FILL_W-1:0] fill_level;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LEN,
      ST_STREAM
   } state_type;

endpackage

@@ design/vlmr_step_unit.sv @@
// ----------------------------------------------------------------------------
// vlmr_step_unit: shared ring index and fill count step
// Advances one ring index with wrap at the active buffer size and moves the
// fill count up or down by one. Serves the tail on writes, the head on reads.
// ----------------------------------------------------------------------------
module vlmr_step_unit #(
   parameter int STORE_DEPTH = 1024
) (
   input  logic [$clog2(STORE_DEPTH)-1:0] idx,
   input  logic [((($clog2(STORE_DEPTH)+1) > vlmr_pkg::FILL_W) ?
                  ($clog2(STORE_DEPTH)+1) : vlmr_pkg::FILL_W)-1:0] size,
   input  logic [vlmr_pkg::FILL_W-1:0] fill,
   input  logic                        up,
   output logic [$clog2(STORE_DEPTH)-1:0] next_idx,
   output logic [vlmr_pkg::FILL_W-1:0]    next_fill
);

   localparam int IDX_W = $clog2(STORE_DEPTH);
   localparam int CNT_W = ((IDX_W + 1) > vlmr_pkg::FILL_W) ? (IDX_W + 1) : vlmr_pkg::FILL_W;

   logic [CNT_W-1:0] inc;

   always_comb begin
      inc = CNT_W'(idx) + CNT_W'(1);
      if (inc >= size) begin
         next_idx = '0;
      end else begin
         next_idx = inc[IDX_W-1:0];
      end
      if (up) begin
         next_fill = fill + vlmr_pkg::FILL_W'(1);
      end else if (fill != '0) begin
         next_fill = fill - vlmr_pkg::FILL_W'(1);
      end else begin
         next_fill = fill;
      end
   end

endmodule

@@ design/vlmr_core.sv @@
// ----------------------------------------------------------------------------
// vlmr_core: message ring sequencer, byte store and ring state
// Handles each write byte in the idle state, and reads as a length fetch then
// one byte per cycle while results are taken, through the shared step unit.
// ----------------------------------------------------------------------------
module vlmr_core #(
   parameter int STORE_DEPTH = 1024,
   parameter int MAX_MESSAGE = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        clear,
   input  logic [vlmr_pkg::FILL_W-1:0] buffer_size,
   input  logic                        req_valid,
   input  vlmr_pkg::req_type           req_data,
   output logic                        req_ready,
   output logic                        res_valid,
   output vlmr_pkg::rsp_type           res_data,
   input  logic                        res_ready
);

   localparam int IDX_W = $clog2(STORE_DEPTH);
   localparam int CNT_W = ((IDX_W + 1) > vlmr_pkg::FILL_W) ? (IDX_W + 1) : vlmr_pkg::FILL_W;
   localparam logic [7:0] MAX_LEN = 8'(MAX_MESSAGE);

   logic [7:0] store [STORE_DEPTH];

   vlmr_pkg::state_type         state_ff, state_in;
   logic [IDX_W-1:0]            head_ff, head_in;
   logic [IDX_W-1:0]            tail_ff, tail_in;
   logic [vlmr_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic [vlmr_pkg::FILL_W-1:0] committed_ff, committed_in;
   logic [7:0]                  left_ff, left_in;
   logic                        dropping_ff, dropping_in;
   logic                        bad_ff, bad_in;
   logic [7:0]                  req_size_ff, req_size_in;
   logic [7:0]                  cnt_ff, cnt_in;
   logic [7:0]                  mem_q_ff;

   logic [CNT_W-1:0]            eff_size;
   logic [CNT_W-1:0]            size_ext;
   logic [CNT_W-1:0]            free_space;
   logic [IDX_W-1:0]            step_idx;
   logic                        step_up;
   logic [IDX_W-1:0]            step_next;
   logic [vlmr_pkg::FILL_W-1:0] step_fill;
   logic [IDX_W-1:0]            rd_addr;
   logic                        mem_we;
   logic [7:0]                  left_dec;
   logic [7:0]                  clamp;

   vlmr_step_unit #(
      .STORE_DEPTH(STORE_DEPTH)
   ) u_step (
      .idx      (step_idx),
      .size     (eff_size),
      .fill     (fill_ff),
      .up       (step_up),
      .next_idx (step_next),
      .next_fill(step_fill)
   );

   // A size of zero acts as one; sizes above the store depth are capped.
   always_comb begin
      size_ext = CNT_W'(buffer_size);
      if (buffer_size == '0) begin
         eff_size = CNT_W'(1);
      end else if (size_ext > CNT_W'(STORE_DEPTH)) begin
         eff_size = CNT_W'(STORE_DEPTH);
      end else begin
         eff_size = size_ext;
      end
      if (CNT_W'(fill_ff) < eff_size) begin
         free_space = eff_size - CNT_W'(fill_ff);
      end else begin
         free_space = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store[tail_ff] <= req_data.write_data;
      end
      mem_q_ff <= store[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         state_ff     <= vlmr_pkg::ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         committed_ff <= '0;
         left_ff      <= '0;
         dropping_ff  <= 1'b0;
         bad_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         committed_ff <= committed_in;
         left_ff      <= left_in;
         dropping_ff  <= dropping_in;
         bad_ff       <= bad_in;
      end
   end

   always_ff @(posedge clock) begin
      req_size_ff <= req_size_in;
      cnt_ff      <= cnt_in;
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      fill_in      = fill_ff;
      committed_in = committed_ff;
      left_in      = left_ff;
      dropping_in  = dropping_ff;
      bad_in       = bad_ff;
      req_size_in  = req_size_ff;
      cnt_in       = cnt_ff;
      req_ready    = 1'b0;
      res_valid    = 1'b0;
      res_data     = '0;
      mem_we       = 1'b0;
      rd_addr      = head_ff;
      step_idx     = head_ff;
      step_up      = 1'b0;
      left_dec     = left_ff - 8'd1;
      clamp        = mem_q_ff;

      unique case (state_ff)
         vlmr_pkg::ST_IDLE: begin
            req_ready           = res_ready;
            step_idx            = tail_ff;
            step_up             = 1'b1;
            res_data.last_byte  = 1'b1;
            res_data.fill_level = fill_ff;
            if (req_data.command == vlmr_pkg::CMD_READ) begin
               if (committed_ff == '0) begin
                  res_valid       = req_valid;
                  res_data.status = vlmr_pkg::STATUS_EMPTY;
               end else if (req_valid && res_ready) begin
                  req_size_in = req_data.request_size;
                  state_in    = vlmr_pkg::ST_LEN;
               end
            end else begin
               res_valid = req_valid;
               if (left_ff != '0) begin
                  // Body byte of an open message: drop or store it.
                  if (dropping_ff) begin
                     res_data.status = bad_ff ? vlmr_pkg::STATUS_BAD_LEN
                                              : vlmr_pkg::STATUS_NO_SPACE;
                     if (req_valid && res_ready) begin
                        left_in = left_dec;
                        if (left_dec == '0) begin
                           dropping_in = 1'b0;
                           bad_in      = 1'b0;
                        end
                     end
                  end else begin
                     res_data.status     = vlmr_pkg::STATUS_STORED;
                     res_data.fill_level = step_fill;
                     if (req_valid && res_ready) begin
                        mem_we  = 1'b1;
                        tail_in = step_next;
                        fill_in = step_fill;
                        left_in = left_dec;
                        if (left_dec == '0) begin
                           committed_in = step_fill;
                        end
                     end
                  end
               end else if (req_data.write_data == '0) begin
                  res_data.status = vlmr_pkg::STATUS_BAD_LEN;
               end else if (req_data.write_data > MAX_LEN ||
                            CNT_W'(req_data.write_data) > free_space) begin
                  // Length byte of a message that is dropped whole.
                  if (req_data.write_data > MAX_LEN) begin
                     res_data.status = vlmr_pkg::STATUS_BAD_LEN;
                  end else begin
                     res_data.status = vlmr_pkg::STATUS_NO_SPACE;
                  end
                  if (req_valid && res_ready) begin
                     left_in     = req_data.write_data - 8'd1;
                     dropping_in = (req_data.write_data != 8'd1);
                     bad_in      = (req_data.write_data > MAX_LEN) &&
                                   (req_data.write_data != 8'd1);
                  end
               end else begin
                  res_data.status     = vlmr_pkg::STATUS_STORED;
                  res_data.fill_level = step_fill;
                  if (req_valid && res_ready) begin
                     mem_we      = 1'b1;
                     tail_in     = step_next;
                     fill_in     = step_fill;
                     left_in     = req_data.write_data - 8'd1;
                     dropping_in = 1'b0;
                     if (req_data.write_data == 8'd1) begin
                        committed_in = step_fill;
                     end
                  end
               end
            end
         end

         vlmr_pkg::ST_LEN: begin
            // The store output now holds the length byte at the head.
            if (mem_q_ff > req_size_ff) begin
               res_valid           = 1'b1;
               res_data.status     = vlmr_pkg::STATUS_TOO_SMALL;
               res_data.last_byte  = 1'b1;
               res_data.fill_level = fill_ff;
               if (res_ready) begin
                  state_in = vlmr_pkg::ST_IDLE;
               end
            end else begin
               if (clamp > MAX_LEN) begin
                  clamp = MAX_LEN;
               end
               if (vlmr_pkg::FILL_W'(clamp) > committed_ff) begin
                  clamp = committed_ff[7:0];
               end
               if (clamp == '0) begin
                  clamp = 8'd1;
               end
               cnt_in   = clamp;
               state_in = vlmr_pkg::ST_STREAM;
            end
         end

         vlmr_pkg::ST_STREAM: begin
            res_valid           = 1'b1;
            res_data.read_data  = mem_q_ff;
            res_data.status     = vlmr_pkg::STATUS_READ_BYTE;
            res_data.last_byte  = (cnt_ff == 8'd1);
            res_data.fill_level = step_fill;
            if (res_ready) begin
               // Fetch the next head byte so that it is ready next cycle.
               rd_addr = step_next;
               head_in = step_next;
               fill_in = step_fill;
               cnt_in  = cnt_ff - 8'd1;
               if (committed_ff != '0) begin
                  committed_in = committed_ff - vlmr_pkg::FILL_W'(1);
               end
               if (cnt_ff == 8'd1) begin
                  state_in = vlmr_pkg::ST_IDLE;
               end
            end
         end

         default: begin
            state_in = vlmr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ design/variable_length_message_ring_fifo_unit.sv @@
// ----------------------------------------------------------------------------
// variable_length_message_ring_fifo_unit: whole-message byte ring FIFO
// Stores length-prefixed messages byte by byte and returns the oldest whole
// message on a read request, with drop and error reporting.
// ----------------------------------------------------------------------------
//   Port group   Direction   Carries
//   req_*        in          one request: command, write byte, request size
//   rsp_*        out         one result: read byte, last mark, status, fill
//   csr_*        in/out      buffer_size register, byte address 0
//
// A write request or an error read is answered from the idle state; an error
// found in the length byte is answered after the length fetch. A read that
// returns a message is accepted, then fetches the length byte from the
// registered store output, then returns its bytes through the shared index unit.
// Reset clears the ring pointers and counts but not the byte store; writing
// buffer_size clears them as well. A low rsp_ready holds a full output register and the sequencer.
module variable_length_message_ring_fifo_unit #(
   parameter int STORE_DEPTH = 1024,
   parameter int MAX_MESSAGE = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  vlmr_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vlmr_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   logic [vlmr_pkg::FILL_W-1:0] buffer_size_ff;
   logic                        csr_write;
   logic                        ring_clear;
   logic                        rsp_valid_ff;
   vlmr_pkg::rsp_type           rsp_data_ff;
   logic                        res_valid;
   vlmr_pkg::rsp_type           res_data;
   logic                        slot_free;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign ring_clear = csr_write && (csr_paddr[2] == vlmr_pkg::CSR_BUFFER_SIZE);

   always_comb begin
      if (csr_paddr[2] == vlmr_pkg::CSR_BUFFER_SIZE) begin
         csr_prdata = 32'(buffer_size_ff);
      end else begin
         csr_prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_size_ff <= vlmr_pkg::BUFFER_SIZE_RESET;
      end else if (ring_clear) begin
         buffer_size_ff <= csr_pwdata[vlmr_pkg::FILL_W-1:0];
      end
   end

   vlmr_core #(
      .STORE_DEPTH(STORE_DEPTH),
      .MAX_MESSAGE(MAX_MESSAGE)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .clear      (ring_clear),
      .buffer_size(buffer_size_ff),
      .req_valid  (req_valid),
      .req_data   (req_data),
      .req_ready  (req_ready),
      .res_valid  (res_valid),
      .res_data   (res_data),
      .res_ready  (slot_free)
   );

   // Output register: a new result loads while the old one leaves.
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_valid && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && slot_free) begin
         rsp_data_ff <= res_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_accept_needs_slot: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> (!rsp_valid_ff || rsp_ready))
      else $error("request accepted while the result register was blocked");

   a_write_answers_next: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.command == vlmr_pkg::CMD_WRITE)
      |=> rsp_valid)
      else $error("write request did not produce a result in the next cycle");

   a_single_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == vlmr_pkg::STATUS_READ_BYTE ||
                     rsp_data.last_byte))
      else $error("single-result status without last mark");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.fill_level <= buffer_size_ff ||
                     rsp_data.fill_level <= vlmr_pkg::FILL_W'(1)))
      else $error("fill level beyond the active buffer size");

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the message ring FIFO
// Writes length-prefixed messages and read commands through the request
// channel under random stalls on both sides, resizes the ring between phases,
// and compares every result against a cycle-free ring model or a literal row.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

   localparam int          STORE_DEPTH      = 1024;
   localparam int          MAX_MESSAGE      = 64;
   localparam int          CYCLE_LIMIT      = 400000;
   localparam int          PHASE_REQUESTS   = 52;
   localparam int          PHASE_COUNT      = 5;
   localparam logic [2:0]  BUFFER_SIZE_ADDR = {vlmr_pkg::CSR_BUFFER_SIZE, 2'b00};

   typedef enum logic [1:0] {
      ROW_SEND,
      ROW_SEND_LITERAL,
      ROW_RESIZE
   } row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      vlmr_pkg::req_type request;
      vlmr_pkg::rsp_type result;
      logic [31:0]       size_value;
   } stim_row_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   vlmr_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   vlmr_pkg::rsp_type rsp_data;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [2:0]        csr_paddr;
   logic [31:0]       csr_pwdata;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   // A literal expectation travels with the request it belongs to.
   logic              literal_valid;
   vlmr_pkg::rsp_type literal_result;
   logic              steady;

   // Ring model state.
   logic [7:0]  ring_bytes [STORE_DEPTH];
   logic [10:0] size_reg;
   int unsigned rd_ptr;
   int unsigned wr_ptr;
   int unsigned held;
   int unsigned open_left;
   int unsigned sealed;
   bit          discarding;
   bit          discard_bad;

   vlmr_pkg::rsp_type step_results [$];
   vlmr_pkg::rsp_type pending_results [$];
   int unsigned       cycle_count;
   int unsigned       error_count;
   int unsigned       result_count;

   variable_length_message_ring_fifo_unit DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #2 clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(0, 99) >= 29);
   end

   function automatic int unsigned active_size();
      if (size_reg == 0) return 1;
      if (size_reg > STORE_DEPTH) return STORE_DEPTH;
      return 32'(size_reg);
   endfunction

   function automatic int unsigned advance(int unsigned i);
      return (i + 1 >= active_size()) ? 0 : i + 1;
   endfunction

   task automatic clear_ring_model();
      rd_ptr      = 0;
      wr_ptr      = 0;
      held        = 0;
      open_left   = 0;
      sealed      = 0;
      discarding  = 0;
      discard_bad = 0;
   endtask

   task automatic add_result(logic [7:0] data, logic last, logic [2:0] status);
      vlmr_pkg::rsp_type r;
      r.read_data  = data;
      r.last_byte  = last;
      r.status     = status;
      r.fill_level = held[vlmr_pkg::FILL_W-1:0];
      step_results.push_back(r);
   endtask

   task automatic store_ring_byte(logic [7:0] b);
      ring_bytes[wr_ptr] = b;
      wr_ptr = advance(wr_ptr);
      held++;
   endtask

   // Works out the results of one accepted request and advances the ring.
   task automatic compute_ring_results(vlmr_pkg::req_type r);
      int unsigned room;
      int unsigned len;
      logic [7:0]  b;
      logic [2:0]  st;
      step_results.delete();
      if (r.command == vlmr_pkg::CMD_WRITE) begin
         if (open_left != 0) begin
            open_left--;
            if (discarding) begin
               st = discard_bad ? vlmr_pkg::STATUS_BAD_LEN : vlmr_pkg::STATUS_NO_SPACE;
               if (open_left == 0) begin
                  discarding  = 0;
                  discard_bad = 0;
               end
               add_result(8'd0, 1'b1, st);
            end else begin
               store_ring_byte(r.write_data);
               if (open_left == 0) sealed = held;
               add_result(8'd0, 1'b1, vlmr_pkg::STATUS_STORED);
            end
         end else begin
            room = (held < active_size()) ? active_size() - held : 0;
            if (r.write_data == 0) begin
               add_result(8'd0, 1'b1, vlmr_pkg::STATUS_BAD_LEN);
            end else if (r.write_data > MAX_MESSAGE || r.write_data > room) begin
               // The length byte opens a message whose remaining bytes are all dropped.
               open_left   = r.write_data - 1;
               discard_bad = (r.write_data > MAX_MESSAGE);
               discarding  = (open_left != 0);
               st = discard_bad ? vlmr_pkg::STATUS_BAD_LEN : vlmr_pkg::STATUS_NO_SPACE;
               if (!discarding) discard_bad = 0;
               add_result(8'd0, 1'b1, st);
            end else begin
               store_ring_byte(r.write_data);
               open_left  = r.write_data - 1;
               discarding = 0;
               if (open_left == 0) sealed = held;
               add_result(8'd0, 1'b1, vlmr_pkg::STATUS_STORED);
            end
         end
      end else if (sealed == 0) begin
         add_result(8'd0, 1'b1, vlmr_pkg::STATUS_EMPTY);
      end else begin
         len = 32'(ring_bytes[rd_ptr]);
         if (len > r.request_size) begin
            add_result(8'd0, 1'b1, vlmr_pkg::STATUS_TOO_SMALL);
         end else begin
            if (len > MAX_MESSAGE) len = MAX_MESSAGE;
            if (len > sealed) len = sealed;
            if (len == 0) len = 1;
            for (int unsigned k = 0; k < len; k++) begin
               b = ring_bytes[rd_ptr];
               rd_ptr = advance(rd_ptr);
               if (held != 0) held--;
               if (sealed != 0) sealed--;
               add_result(b, (k + 1 == len), vlmr_pkg::STATUS_READ_BYTE);
            end
         end
      end
   endtask

   task automatic report_mismatch(string what);
      $display("MISMATCH cycle %0d result %0d: %s", cycle_count, result_count, what);
      error_count++;
   endtask

   always @(posedge clock) begin : monitor
      vlmr_pkg::rsp_type want;
      cycle_count++;
      if (!reset) begin
         if (req_valid && req_ready) begin
            compute_ring_results(req_data);
            if (literal_valid) pending_results.push_back(literal_result);
            else foreach (step_results[i]) pending_results.push_back(step_results[i]);
         end
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("unexpected result status %0d", rsp_data.status));
            end else begin
               want = pending_results.pop_front();
               if (rsp_data.read_data !== want.read_data)
                  report_mismatch($sformatf("read_data %0d, expected %0d",
                                            rsp_data.read_data, want.read_data));
               if (rsp_data.last_byte !== want.last_byte)
                  report_mismatch($sformatf("last_byte %0d, expected %0d",
                                            rsp_data.last_byte, want.last_byte));
               if (rsp_data.status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_data.status, want.status));
               if (rsp_data.fill_level !== want.fill_level)
                  report_mismatch($sformatf("fill_level %0d, expected %0d",
                                            rsp_data.fill_level, want.fill_level));
            end
         end
      end
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Entered and left at a falling edge; valid stays high into the next request
   // unless a gap is drawn.
   task automatic send_request(vlmr_pkg::req_type r, logic use_literal,
                               vlmr_pkg::rsp_type literal);
      while (!steady && $urandom_range(0, 99) < 29) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_data       <= r;
      literal_valid  <= use_literal;
      literal_result <= literal;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
   endtask

   task automatic write_buffer_size(logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= BUFFER_SIZE_ADDR;
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      size_reg = value[10:0];
      clear_ring_model();
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic pick_random_request(output vlmr_pkg::req_type r);
      int unsigned roll;
      logic [7:0]  head_len;
      r.write_data   = 8'($urandom_range(0, 255));
      r.request_size = 8'($urandom_range(0, 255));
      roll = $urandom_range(0, 99);
      if (open_left != 0 && roll >= 8) begin
         r.command = vlmr_pkg::CMD_WRITE;
      end else if (open_left != 0 || roll < 25) begin
         r.command = vlmr_pkg::CMD_READ;
         if (sealed != 0) begin
            // Mostly ask for enough room for the oldest message, sometimes too little.
            head_len = ring_bytes[rd_ptr];
            roll = $urandom_range(0, 99);
            if (roll < 75) r.request_size = 8'($urandom_range(head_len, 255));
            else if (roll < 90) r.request_size = 8'($urandom_range(0, head_len - 1));
         end
      end else begin
         r.command = vlmr_pkg::CMD_WRITE;
         roll = $urandom_range(0, 99);
         if (roll < 4)
            r.write_data = 8'd0;
         else if (roll < 7)
            r.write_data = ($urandom_range(0, 9) == 0) ? 8'd255
                           : 8'($urandom_range(MAX_MESSAGE + 1, MAX_MESSAGE + 4));
         else if (roll < 70)
            r.write_data = 8'($urandom_range(1, 8));
         else if (roll < 93)
            r.write_data = 8'($urandom_range(9, 40));
         else
            r.write_data = 8'($urandom_range(41, MAX_MESSAGE));
      end
   endtask

   function automatic stim_row_type send_row(logic cmd, logic [7:0] wd, logic [7:0] rs);
      stim_row_type row;
      row                      = '0;
      row.kind                 = ROW_SEND;
      row.request.command      = cmd;
      row.request.write_data   = wd;
      row.request.request_size = rs;
      return row;
   endfunction

   function automatic stim_row_type literal_row(logic cmd, logic [7:0] wd, logic [7:0] rs,
                                                logic [7:0] data, logic [2:0] st,
                                                logic [vlmr_pkg::FILL_W-1:0] fill);
      stim_row_type row;
      row                   = send_row(cmd, wd, rs);
      row.kind              = ROW_SEND_LITERAL;
      row.result.read_data  = data;
      row.result.last_byte  = 1'b1;
      row.result.status     = st;
      row.result.fill_level = fill;
      return row;
   endfunction

   function automatic stim_row_type resize_row(logic [31:0] value);
      stim_row_type row;
      row            = '0;
      row.kind       = ROW_RESIZE;
      row.size_value = value;
      return row;
   endfunction

   initial begin : stimulus
      stim_row_type      directed_rows [$];
      vlmr_pkg::req_type r;
      logic [31:0]       phase_size;

      clock          = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_ready      = 1'b0;
      literal_valid  = 1'b0;
      literal_result = '0;
      steady         = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;
      cycle_count    = 0;
      error_count    = 0;
      result_count   = 0;
      foreach (ring_bytes[i]) ring_bytes[i] = 8'd0;
      size_reg = vlmr_pkg::BUFFER_SIZE_RESET;
      clear_ring_model();

      // Empty read, zero length, one-byte message, short request, read-back.
      directed_rows.push_back(literal_row(vlmr_pkg::CMD_READ, 8'h00, 8'hFF, 8'd0,
                                          vlmr_pkg::STATUS_EMPTY, 11'd0));
      directed_rows.push_back(literal_row(vlmr_pkg::CMD_WRITE, 8'h00, 8'h00, 8'd0,
                                          vlmr_pkg::STATUS_BAD_LEN, 11'd0));
      directed_rows.push_back(literal_row(vlmr_pkg::CMD_WRITE, 8'h01, 8'hFF, 8'd0,
                                          vlmr_pkg::STATUS_STORED, 11'd1));
      directed_rows.push_back(literal_row(vlmr_pkg::CMD_READ, 8'hFF, 8'h00, 8'd0,
                                          vlmr_pkg::STATUS_TOO_SMALL, 11'd1));
      directed_rows.push_back(literal_row(vlmr_pkg::CMD_READ, 8'h00, 8'hFF, 8'd1,
                                          vlmr_pkg::STATUS_READ_BYTE, 11'd0));
      // A three-byte message, then a second one left open while reading the first.
      directed_rows.push_back(send_row(vlmr_pkg::CMD_WRITE, 8'h03, 8'h00));
      directed_rows.push_back(send_row(vlmr_pkg::CMD_WRITE, 8'hFF, 8'hFF));
      directed_rows.push_back(send_row(vlmr_pkg::CMD_WRITE, 8'h00, 8'h00));
      directed_rows.push_back(send_row(vlmr_pkg::CMD_WRITE, 8'h04, 8'h00));
      directed_rows.push_back(send_row(vlmr_pkg::CMD_READ, 8'h00, 8'h03));
      // An unfinished message cannot be read.
      directed_rows.push_back(literal_row(vlmr_pkg::CMD_READ, 8'h00, 8'hFF, 8'd0,
                                          vlmr_pkg::STATUS_EMPTY, 11'd1));
      directed_rows.push_back(send_row(vlmr_pkg::CMD_WRITE, 8'hAA, 8'h00));
      directed_rows.push_back(send_row(vlmr_pkg::CMD_WRITE, 8'h55, 8'h00));
      directed_rows.push_back(send_row(vlmr_pkg::CMD_WRITE, 8'h01, 8'h00));
      directed_rows.push_back(literal_row(vlmr_pkg::CMD_WRITE, 8'd65, 8'h00, 8'd0,
                                          vlmr_pkg::STATUS_BAD_LEN, 11'd4));
      // Too long for a 16-byte ring; the resize also abandons the open drop.
      directed_rows.push_back(resize_row(32'd16));
      directed_rows.push_back(literal_row(vlmr_pkg::CMD_WRITE, 8'd17, 8'h00, 8'd0,
                                          vlmr_pkg::STATUS_NO_SPACE, 11'd0));
      // A size of zero behaves as a single slot.
      directed_rows.push_back(resize_row(32'd0));
      directed_rows.push_back(literal_row(vlmr_pkg::CMD_WRITE, 8'h01, 8'h00, 8'd0,
                                          vlmr_pkg::STATUS_STORED, 11'd1));
      directed_rows.push_back(literal_row(vlmr_pkg::CMD_WRITE, 8'h01, 8'h00, 8'd0,
                                          vlmr_pkg::STATUS_NO_SPACE, 11'd1));
      directed_rows.push_back(literal_row(vlmr_pkg::CMD_READ, 8'h00, 8'hFF, 8'd1,
                                          vlmr_pkg::STATUS_READ_BYTE, 11'd0));
      directed_rows.push_back(literal_row(vlmr_pkg::CMD_WRITE, 8'h02, 8'h00, 8'd0,
                                          vlmr_pkg::STATUS_NO_SPACE, 11'd0));
      directed_rows.push_back(send_row(vlmr_pkg::CMD_WRITE, 8'h80, 8'h00));
      // Sizes beyond the store clamp to its depth.
      directed_rows.push_back(resize_row(32'h0000_07FF));
      directed_rows.push_back(literal_row(vlmr_pkg::CMD_WRITE, 8'hFF, 8'h00, 8'd0,
                                          vlmr_pkg::STATUS_BAD_LEN, 11'd0));

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         case (directed_rows[i].kind)
            ROW_RESIZE: begin
               wait_drained();
               write_buffer_size(directed_rows[i].size_value);
            end
            ROW_SEND_LITERAL: begin
               send_request(directed_rows[i].request, 1'b1, directed_rows[i].result);
            end
            default: begin
               send_request(directed_rows[i].request, 1'b0, '0);
            end
         endcase
      end

      // Random phases, each on a fresh ring size; upper data bits of the first
      // size are outside the register and must be ignored.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0:       phase_size = 32'h0000_F828;
            1:       phase_size = 32'd1024;
            2:       phase_size = 32'd1;
            3:       phase_size = 32'd100;
            default: phase_size = $urandom_range(2, STORE_DEPTH);
         endcase
         wait_drained();
         steady = (phase == 3);
         write_buffer_size(phase_size);
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            if (phase == 0 && n == PHASE_REQUESTS / 2) wait_drained();
            pick_random_request(r);
            send_request(r, 1'b0, '0);
         end
      end

      wait_drained();
      steady = 1'b0;
      repeat (MAX_MESSAGE + 4) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
